FILE: hdl/tds_pkg.sv
// tds_pkg: shared types, codes and constants of the thermometer display scanner
// no dependencies; imported by thermo_display_scanner_unit
package tds_pkg;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_t;

  typedef enum logic {
    REG_BLANK_START  = 1'b0,
    REG_BLINK_PERIOD = 1'b1
  } reg_idx_t;

  localparam int TEMP_W  = 9;
  localparam int LIMIT_W = 6;
  localparam int BLINK_W = 8;
  localparam int BCD_W   = 4;
  localparam int SEL_W   = 4;
  localparam int SLOT_W  = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // degrees per full scale with the tenths already folded in
  localparam int unsigned TEMP_SCALE  = 330;
  localparam int unsigned LIMIT_SCALE = 50;

  localparam logic [BLINK_W-1:0] BLANK_START_RST  = 8'd70;
  localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST = 8'd140;

  localparam logic [SEL_W-1:0] SEL_ALL_OFF = 4'hF;

  typedef struct packed {
    logic [BCD_W-1:0] tens;
    logic [BCD_W-1:0] ones;
  } bcd_pair_t;

  // split a value below 512 into tens and ones, tens truncated to 4 bits
  function automatic bcd_pair_t split_dec(input logic [TEMP_W-1:0] v);
    logic [TEMP_W+11-1:0] prod;
    logic [TEMP_W-1:0]    q;
    logic [TEMP_W+3-1:0]  q10;
    logic [TEMP_W-1:0]    r;
    bcd_pair_t            res;
    prod     = {11'd0, v} * (TEMP_W + 11)'(205);
    q        = prod[TEMP_W+11-1:11];
    q10      = {3'd0, q} * (TEMP_W + 3)'(10);
    r        = v - q10[TEMP_W-1:0];
    res.tens = q[BCD_W-1:0];
    res.ones = r[BCD_W-1:0];
    return res;
  endfunction

endpackage

FILE: hdl/thermo_display_scanner_unit.sv
// thermo_display_scanner_unit: converter scaling and multiplexed four-digit display scan
// depends on tds_pkg
//
//  port group   dir   handshake          payload
//  in_*         in    in_valid/in_stall  in_func, in_temp_sample, in_limit_sample
//  out_*        out   out_valid/out_stall out_digit_select, out_bcd_digit, out_indicator
//  apb          in    psel/penable       paddr, pwdata, prdata (reg 0 at 0, reg 1 at 4)
//
//  one word per cycle sustained while the output is not stalled; a tick word is
//  registered in the input register at acceptance, then in the result register
//  scaling is a constant multiply and two end-around folds by 2^SAMPLE_BITS-1
//  synchronous active-low reset; valid and state registers reset, data registers do not
//  an output stall holds the result register; tick words back up in the input register
module thermo_display_scanner_unit #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [SAMPLE_BITS-1:0]       in_temp_sample,
  input  logic [SAMPLE_BITS-1:0]       in_limit_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tds_pkg::SEL_W-1:0]    out_digit_select,
  output logic [tds_pkg::BCD_W-1:0]    out_bcd_digit,
  output logic                         out_indicator,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tds_pkg::ADDR_W-1:0]   paddr,
  input  logic [tds_pkg::DATA_W-1:0]   pwdata,
  output logic [tds_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import tds_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + TEMP_W;
  localparam int RW = SB + 2;
  localparam logic [SB:0] FS = {1'b0, {SB{1'b1}}};

  // floor(p / (2^SB - 1)) by two end-around folds and one correction
  function automatic logic [TEMP_W-1:0] div_fs(input logic [PW-1:0] p);
    logic [TEMP_W-1:0] q0;
    logic [RW-1:0]     r1;
    logic [1:0]        q1;
    logic [SB:0]       r2;
    logic              c;
    q0 = p[PW-1:SB];
    r1 = {2'b00, p[SB-1:0]} + RW'(q0);
    q1 = r1[RW-1:SB];
    r2 = {1'b0, r1[SB-1:0]} + (SB + 1)'(q1);
    c  = (r2 >= FS);
    return q0 + TEMP_W'(q1) + TEMP_W'(c);
  endfunction

  logic                   s1_valid_r;
  logic                   s1_func_r;
  logic [SB-1:0]          s1_x_r;
  logic [SB-1:0]          s1_a_r;
  logic [BLINK_W-1:0]     blank_start_r;
  logic [BLINK_W-1:0]     blink_period_r;
  logic [TEMP_W-1:0]      temperature_r, temperature_nxt;
  logic [LIMIT_W-1:0]     limit_r, limit_nxt;
  logic [SLOT_W-1:0]      scan_slot_r, scan_slot_nxt;
  logic [BLINK_W-1:0]     blink_count_r, blink_count_nxt;
  logic [BCD_W-1:0]       held_bcd_r, held_bcd_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SEL_W-1:0]       sel_r, sel_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                   ind_r, ind_nxt;

  logic                   accept;
  logic                   fire;
  logic                   is_tick;
  logic                   below;
  logic                   blank;
  logic                   cfg_wr;
  logic [PW-1:0]          temp_prod;
  logic [PW-1:0]          limit_prod;
  logic [TEMP_W-1:0]      limit_q;
  logic [BLINK_W-1:0]     blink_base;
  bcd_pair_t              temp_dec;
  bcd_pair_t              limit_dec;
  logic [BCD_W-1:0]       slot_digit;
  reg_idx_t               reg_idx;

  assign is_tick  = (s1_func_r == FUNC_TICK);
  assign fire     = s1_valid_r && (!is_tick || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !fire;
  assign accept   = in_valid && !in_stall;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_BLANK_START:  prdata = {{(DATA_W-BLINK_W){1'b0}}, blank_start_r};
      REG_BLINK_PERIOD: prdata = {{(DATA_W-BLINK_W){1'b0}}, blink_period_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_start_r  <= BLANK_START_RST;
      blink_period_r <= BLINK_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BLANK_START:  blank_start_r  <= pwdata[BLINK_W-1:0];
        REG_BLINK_PERIOD: blink_period_r <= pwdata[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_func;
      s1_x_r    <= in_temp_sample;
      s1_a_r    <= in_limit_sample;
    end
  end

  // scaling
  assign temp_prod  = {{TEMP_W{1'b0}}, s1_x_r} * PW'(TEMP_SCALE);
  assign limit_prod = {{TEMP_W{1'b0}}, s1_a_r} * PW'(LIMIT_SCALE);
  assign limit_q    = div_fs(limit_prod);

  // tick
  assign temp_dec   = split_dec(temperature_r);
  assign limit_dec  = split_dec({{(TEMP_W-LIMIT_W){1'b0}}, limit_r});
  assign below      = (temperature_r < {{(TEMP_W-LIMIT_W){1'b0}}, limit_r});
  assign blank      = (blink_count_r > blank_start_r) && (blink_count_r < blink_period_r)
                      && below;
  assign blink_base = (blink_count_r == blink_period_r) ? '0 : blink_count_r;

  always_comb begin
    unique case (scan_slot_r)
      2'd0:    slot_digit = temp_dec.tens;
      2'd1:    slot_digit = temp_dec.ones;
      2'd2:    slot_digit = limit_dec.tens;
      default: slot_digit = limit_dec.ones;
    endcase
  end

  always_comb begin
    temperature_nxt = temperature_r;
    limit_nxt       = limit_r;
    scan_slot_nxt   = scan_slot_r;
    blink_count_nxt = blink_count_r;
    held_bcd_nxt    = held_bcd_r;
    sel_nxt         = sel_r;
    bcd_nxt         = bcd_r;
    ind_nxt         = ind_r;
    out_valid_nxt   = out_valid_r && out_stall;
    if (fire) begin
      if (!is_tick) begin
        temperature_nxt = div_fs(temp_prod);
        limit_nxt       = limit_q[LIMIT_W-1:0];
      end else begin
        out_valid_nxt   = 1'b1;
        blink_count_nxt = blink_base + BLINK_W'(1);
        if (blank) begin
          sel_nxt = SEL_ALL_OFF;
          bcd_nxt = held_bcd_r;
          ind_nxt = 1'b0;
        end else begin
          sel_nxt       = ~(SEL_W'(1) << scan_slot_r);
          bcd_nxt       = slot_digit;
          ind_nxt       = below;
          held_bcd_nxt  = slot_digit;
          scan_slot_nxt = scan_slot_r + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temperature_r <= '0;
      limit_r       <= '0;
      scan_slot_r   <= '0;
      blink_count_r <= '0;
      held_bcd_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      temperature_r <= temperature_nxt;
      limit_r       <= limit_nxt;
      scan_slot_r   <= scan_slot_nxt;
      blink_count_r <= blink_count_nxt;
      held_bcd_r    <= held_bcd_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    bcd_r <= bcd_nxt;
    ind_r <= ind_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = sel_r;
  assign out_bcd_digit    = bcd_r;
  assign out_indicator    = ind_r;

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(~out_digit_select) <= 1)
    else $error("more than one digit enabled");

  a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_digit_select == SEL_ALL_OFF) |-> !out_indicator)
    else $error("indicator lit on blanked word");

  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_tick && !blank) |=> scan_slot_r == $past(scan_slot_r) + SLOT_W'(1))
    else $error("scan slot did not advance");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    temperature_r <= TEMP_W'(TEMP_SCALE) && limit_r <= LIMIT_W'(LIMIT_SCALE))
    else $error("scaled value out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without backpressure");

endmodule
